// ----- src/dmc_pkg.sv -----
// shared constants and codes for the depth-first maze carver
`default_nettype none

package dmc_pkg;

	localparam int MAX_SIDE_DEF = 64;   // largest maze side supported by default
	localparam int RAND_W       = 16;   // width of the random words
	localparam int CFG_W        = 7;    // width of a side register
	localparam int CFG_IDX_W    = 1;    // width of the register index
	localparam int COORD_W      = 6;    // width of a reported coordinate
	localparam int DIR_W        = 3;    // width of the move code
	localparam int EPOCH_W      = 8;    // generation tag kept per visited entry
	localparam int MIN_SIDE     = 2;

	localparam int DIV_VW_DEF   = $clog2(MAX_SIDE_DEF + 1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

	// move codes
	localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
	localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd3;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd4;
	localparam logic [DIR_W-1:0] DIR_POP   = 3'd5;

endpackage

`default_nettype wire

// ----- src/dmc_modu.sv -----
// iterative remainder unit, one dividend bit per cycle
`default_nettype none

module dmc_modu #(
	parameter int DW = dmc_pkg::RAND_W,
	parameter int VW = dmc_pkg::DIV_VW_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          go,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic               done,
	output logic [VW-1:0]      rem
);
	import dmc_pkg::*;

	localparam int CNTW = $clog2(DW + 1);

	logic [VW-1:0]   rem_q;
	logic [VW-1:0]   div_q;
	logic [DW-1:0]   dsr_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [VW:0] trial;
	logic [VW:0] diff;
	logic        fits;

	// restoring step: shift in the next dividend bit, subtract when it fits
	assign trial = {rem_q, dsr_q[DW-1]};
	assign fits  = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			div_q  <= '0;
			dsr_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (go) begin
			rem_q  <= '0;
			div_q  <= divisor;
			dsr_q  <= dividend;
			cnt_q  <= CNTW'(DW);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[VW-1:0] : trial[VW-1:0];
			dsr_q <= {dsr_q[DW-2:0], 1'b0};
			cnt_q <= cnt_q - CNTW'(1);
			if (cnt_q == CNTW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	a_go_starts: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> busy_q && !done_q)
		else $error("remainder unit did not start");

	a_last_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !go && cnt_q == CNTW'(1)) |=> done_q && !busy_q)
		else $error("remainder unit missed its last step");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && div_q != '0) |-> rem_q < div_q)
		else $error("remainder not below divisor");

endmodule

`default_nettype wire

// ----- src/dfs_maze_carver_top.sv -----
// depth-first maze carver: visited and stack memories, step sequencer, output register
// walk step: ST_RD1, ST_EVAL and ST_EMIT, plus ST_POP on a backtrack, with ST_RD1 set by
//   the two-port visited memory read of the neighbours; no new request until back in idle
// start: waits in ST_DIV on the bit-serial remainder units for the start cell
// reset: control cleared, then a pass clearing all 2**(2*clog2(MAX_SIDE)) entries (4096 at
//   the default) of the visited memory with in_ready low; the same pass runs inside the
//   start transaction whenever the 8-bit generation tag wraps (256th start, then every 255th)
`default_nettype none

module dfs_maze_carver_top #(
	parameter int MAX_SIDE = dmc_pkg::MAX_SIDE_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [dmc_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [dmc_pkg::CFG_W-1:0]      cfg_wdata,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           start_req,
	input  wire logic [dmc_pkg::RAND_W-1:0]     rand_a,
	input  wire logic [dmc_pkg::RAND_W-1:0]     rand_b,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [dmc_pkg::COORD_W-1:0]         cell_x,
	output logic [dmc_pkg::COORD_W-1:0]         cell_y,
	output logic [dmc_pkg::DIR_W-1:0]           move_dir,
	output logic                                maze_done
);
	import dmc_pkg::*;

	localparam int XW     = $clog2(MAX_SIDE);
	localparam int SW     = $clog2(MAX_SIDE + 1);
	localparam int AW     = 2 * XW;
	localparam int VDEPTH = 1 << AW;
	localparam int CELLS  = MAX_SIDE * MAX_SIDE;
	localparam int SAW    = $clog2(CELLS);
	localparam int SPW    = $clog2(CELLS + 1);
	localparam int CW     = 2 * SW;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RD1   = 3'd2;
	localparam logic [2:0] ST_EVAL  = 3'd3;
	localparam logic [2:0] ST_POP   = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	function automatic logic [1:0] mod3(input logic [RAND_W-1:0] v);
		logic [4:0] s;
		logic [2:0] t;
		logic [2:0] u;
		s = '0;
		// base-4 digits sum to the same residue mod 3
		for (int i = 0; i < RAND_W / 2; i++) begin
			s = s + 5'(v[2*i +: 2]);
		end
		t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
		u = 3'(t[1:0]) + 3'(t[2]);
		if (u >= 3'd3) begin
			u = u - 3'd3;
		end
		return u[1:0];
	endfunction

	// control and state registers
	logic [2:0]         state_q;
	logic [CFG_W-1:0]   reg_w_q;
	logic [CFG_W-1:0]   reg_h_q;
	logic [SW-1:0]      act_w_q;
	logic [SW-1:0]      act_h_q;
	logic [CW-1:0]      area_q;
	logic [CW-1:0]      vcount_q;
	logic [SPW-1:0]     sp_q;
	logic [XW-1:0]      cur_x_q;
	logic [XW-1:0]      cur_y_q;
	logic               active_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [AW-1:0]      clr_addr_q;
	logic               start_pend_q;
	logic               div_go_q;
	logic [RAND_W-1:0]  ra_q;
	logic [RAND_W-1:0]  rb_q;
	logic [1:0]         ra_mod3_q;
	logic               up_hit_q;
	logic               left_hit_q;
	logic [DIR_W-1:0]   dir_q;

	// output register
	logic               out_valid_q;
	logic [COORD_W-1:0] cell_x_q;
	logic [COORD_W-1:0] cell_y_q;
	logic [DIR_W-1:0]   move_dir_q;
	logic               maze_done_q;

	// memories
	logic [EPOCH_W-1:0] vmem [VDEPTH];
	logic [AW-1:0]      stk_mem [CELLS];
	logic [EPOCH_W-1:0] vrd_a_q;
	logic [EPOCH_W-1:0] vrd_b_q;
	logic [AW-1:0]      stk_rd_q;

	logic [AW-1:0]      addr_up;
	logic [AW-1:0]      addr_left;
	logic [AW-1:0]      addr_right;
	logic [AW-1:0]      addr_down;
	logic [AW-1:0]      rd_addr_a;
	logic [AW-1:0]      rd_addr_b;
	logic               vm_we;
	logic [AW-1:0]      vm_waddr;
	logic [EPOCH_W-1:0] vm_wdata;
	logic               push_we;
	logic [SPW-1:0]     sp_m1;
	logic [SAW-1:0]     stk_raddr;

	logic [SW-1:0]      w_clamp;
	logic [SW-1:0]      h_clamp;
	logic               done_w;
	logic               emit_load;

	logic               has_up;
	logic               has_left;
	logic               has_right;
	logic               has_down;
	logic [3:0]         cand;
	logic [2:0]         n_cand;
	logic [1:0]         pick;
	logic [2:0]         seen;
	logic [1:0]         sel_idx;
	logic [XW-1:0]      nxt_x;
	logic [XW-1:0]      nxt_y;
	logic [DIR_W-1:0]   sel_dir;

	logic               done_x;
	logic               done_y;
	logic               mod_done;
	logic [SW-1:0]      rem_x;
	logic [SW-1:0]      rem_y;

	// start cell column and row
	dmc_modu #(
		.DW (RAND_W),
		.VW (SW)
	) u_mod_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go_q),
		.dividend (ra_q),
		.divisor  (act_w_q),
		.done     (done_x),
		.rem      (rem_x)
	);

	dmc_modu #(
		.DW (RAND_W),
		.VW (SW)
	) u_mod_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go_q),
		.dividend (rb_q),
		.divisor  (act_h_q),
		.done     (done_y),
		.rem      (rem_y)
	);

	assign mod_done = done_x && done_y;

	always_comb begin
		if (reg_w_q < CFG_W'(MIN_SIDE)) begin
			w_clamp = SW'(MIN_SIDE);
		end else if (32'(reg_w_q) > MAX_SIDE) begin
			w_clamp = SW'(MAX_SIDE);
		end else begin
			w_clamp = SW'(reg_w_q);
		end
		if (reg_h_q < CFG_W'(MIN_SIDE)) begin
			h_clamp = SW'(MIN_SIDE);
		end else if (32'(reg_h_q) > MAX_SIDE) begin
			h_clamp = SW'(MAX_SIDE);
		end else begin
			h_clamp = SW'(reg_h_q);
		end
	end

	assign done_w = active_q && (vcount_q >= area_q);

	// neighbour addresses; out-of-grid ones wrap but are masked below
	assign addr_up    = {cur_y_q - XW'(1), cur_x_q};
	assign addr_left  = {cur_y_q, cur_x_q - XW'(1)};
	assign addr_right = {cur_y_q, cur_x_q + XW'(1)};
	assign addr_down  = {cur_y_q + XW'(1), cur_x_q};

	// idle reads up/left and ST_RD1 reads right/down: two read ports, four neighbours
	assign rd_addr_a = (state_q == ST_RD1) ? addr_right : addr_up;
	assign rd_addr_b = (state_q == ST_RD1) ? addr_down : addr_left;

	assign has_up    = cur_y_q != '0;
	assign has_left  = cur_x_q != '0;
	assign has_right = (SW'(cur_x_q) + SW'(1)) < act_w_q;
	assign has_down  = (SW'(cur_y_q) + SW'(1)) < act_h_q;

	assign cand[0] = has_up && !up_hit_q;
	assign cand[1] = has_left && !left_hit_q;
	assign cand[2] = has_right && (vrd_a_q != epoch_q);
	assign cand[3] = has_down && (vrd_b_q != epoch_q);

	assign n_cand = 3'(cand[0]) + 3'(cand[1]) + 3'(cand[2]) + 3'(cand[3]);

	always_comb begin
		unique case (n_cand)
			3'd2:    pick = {1'b0, ra_q[0]};
			3'd3:    pick = ra_mod3_q;
			3'd4:    pick = ra_q[1:0];
			default: pick = 2'd0;
		endcase
	end

	// pick-th free neighbour in up, left, right, down order
	always_comb begin
		seen    = '0;
		sel_idx = '0;
		for (int i = 0; i < 4; i++) begin
			if (cand[i] && seen == {1'b0, pick}) begin
				sel_idx = 2'(i);
			end
			if (cand[i]) begin
				seen = seen + 3'd1;
			end
		end
	end

	always_comb begin
		unique case (sel_idx)
			2'd0: begin
				nxt_x   = cur_x_q;
				nxt_y   = cur_y_q - XW'(1);
				sel_dir = DIR_UP;
			end
			2'd1: begin
				nxt_x   = cur_x_q - XW'(1);
				nxt_y   = cur_y_q;
				sel_dir = DIR_LEFT;
			end
			2'd2: begin
				nxt_x   = cur_x_q + XW'(1);
				nxt_y   = cur_y_q;
				sel_dir = DIR_RIGHT;
			end
			default: begin
				nxt_x   = cur_x_q;
				nxt_y   = cur_y_q + XW'(1);
				sel_dir = DIR_DOWN;
			end
		endcase
	end

	// visited memory write port
	always_comb begin
		vm_we    = 1'b0;
		vm_waddr = clr_addr_q;
		vm_wdata = epoch_q;
		unique case (state_q)
			ST_CLEAR: begin
				vm_we    = 1'b1;
				vm_wdata = '0;
			end
			ST_EVAL: begin
				vm_we    = n_cand != 3'd0;
				vm_waddr = {nxt_y, nxt_x};
			end
			ST_DIV: begin
				vm_we    = mod_done;
				vm_waddr = {rem_y[XW-1:0], rem_x[XW-1:0]};
			end
			default: begin
				vm_we = 1'b0;
			end
		endcase
	end

	assign push_we   = (state_q == ST_EVAL) && (n_cand != 3'd0) && (sp_q < SPW'(CELLS));
	assign sp_m1     = sp_q - SPW'(1);
	assign stk_raddr = sp_m1[SAW-1:0];

	// used visited reads and the writes fall in different states; a push never meets a pop
	always_ff @(posedge clk) begin
		vrd_a_q <= vmem[rd_addr_a];
		vrd_b_q <= vmem[rd_addr_b];
		if (vm_we) begin
			vmem[vm_waddr] <= vm_wdata;
		end
	end

	always_ff @(posedge clk) begin
		stk_rd_q <= stk_mem[stk_raddr];
		if (push_we) begin
			stk_mem[sp_q[SAW-1:0]] <= {cur_y_q, cur_x_q};
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_w_q <= CFG_W'(16);
			reg_h_q <= CFG_W'(16);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_WIDTH:  reg_w_q <= cfg_wdata;
				REG_HEIGHT: reg_h_q <= cfg_wdata;
				default:    reg_w_q <= reg_w_q;
			endcase
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			act_w_q      <= SW'(MIN_SIDE);
			act_h_q      <= SW'(MIN_SIDE);
			area_q       <= CW'(MIN_SIDE * MIN_SIDE);
			vcount_q     <= '0;
			sp_q         <= '0;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			active_q     <= 1'b0;
			epoch_q      <= '0;
			clr_addr_q   <= '0;
			start_pend_q <= 1'b0;
			div_go_q     <= 1'b0;
			ra_q         <= '0;
			rb_q         <= '0;
			ra_mod3_q    <= '0;
			up_hit_q     <= 1'b0;
			left_hit_q   <= 1'b0;
			dir_q        <= DIR_NONE;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == '1) begin
						state_q      <= start_pend_q ? ST_DIV : ST_IDLE;
						div_go_q     <= start_pend_q;
						start_pend_q <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						ra_q      <= rand_a;
						rb_q      <= rand_b;
						ra_mod3_q <= mod3(rand_a);
						if (start_req) begin
							act_w_q  <= w_clamp;
							act_h_q  <= h_clamp;
							active_q <= 1'b0;
							if (epoch_q == '1) begin
								// tag wrap: old marks would alias, so wipe first
								epoch_q      <= EPOCH_W'(1);
								start_pend_q <= 1'b1;
								clr_addr_q   <= '0;
								state_q      <= ST_CLEAR;
							end else begin
								epoch_q  <= epoch_q + EPOCH_W'(1);
								div_go_q <= 1'b1;
								state_q  <= ST_DIV;
							end
						end else if (!active_q || done_w) begin
							dir_q   <= DIR_NONE;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_RD1;
						end
					end
				end
				ST_RD1: begin
					up_hit_q   <= vrd_a_q == epoch_q;
					left_hit_q <= vrd_b_q == epoch_q;
					state_q    <= ST_EVAL;
				end
				ST_EVAL: begin
					if (n_cand != 3'd0) begin
						if (push_we) begin
							sp_q <= sp_q + SPW'(1);
						end
						cur_x_q  <= nxt_x;
						cur_y_q  <= nxt_y;
						vcount_q <= vcount_q + CW'(1);
						dir_q    <= sel_dir;
						state_q  <= ST_EMIT;
					end else if (sp_q != '0) begin
						sp_q    <= sp_m1;
						state_q <= ST_POP;
					end else begin
						dir_q   <= DIR_NONE;
						state_q <= ST_EMIT;
					end
				end
				ST_POP: begin
					cur_y_q <= stk_rd_q[AW-1:XW];
					cur_x_q <= stk_rd_q[XW-1:0];
					dir_q   <= DIR_POP;
					state_q <= ST_EMIT;
				end
				ST_DIV: begin
					div_go_q <= 1'b0;
					area_q   <= CW'(act_w_q) * CW'(act_h_q);
					if (mod_done) begin
						cur_x_q  <= rem_x[XW-1:0];
						cur_y_q  <= rem_y[XW-1:0];
						vcount_q <= CW'(1);
						sp_q     <= '0;
						active_q <= 1'b1;
						dir_q    <= DIR_NONE;
						state_q  <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			cell_x_q    <= COORD_W'(cur_x_q);
			cell_y_q    <= COORD_W'(cur_y_q);
			move_dir_q  <= dir_q;
			maze_done_q <= done_w;
		end
	end

	assign out_valid = out_valid_q;
	assign cell_x    = cell_x_q;
	assign cell_y    = cell_y_q;
	assign move_dir  = move_dir_q;
	assign maze_done = maze_done_q;

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		vm_we |-> (state_q != ST_IDLE && state_q != ST_RD1))
		else $error("visited write collides with neighbour read");

	a_stack_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (32'(sp_q) < 32'(vcount_q)))
		else $error("stack deeper than visited cells");

	a_count_in_area: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> vcount_q <= area_q)
		else $error("visited count beyond maze area");

	a_carve_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL && n_cand != 3'd0) |=>
			(vcount_q == $past(vcount_q) + CW'(1)))
		else $error("carve step did not count the new cell");

endmodule

`default_nettype wire
